FILE: sv/srbf_pkg.sv
// ----------------------------------------------------------------------------
// srbf_pkg
// Shared widths, register indexes, band snapshot type and helper functions
// for the strip row band finder.
// ----------------------------------------------------------------------------
package srbf_pkg;

   localparam int STRIP_COUNT = 8;
   localparam int STRIP_IDX_W = $clog2(STRIP_COUNT);
   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;

   localparam int DIM_W  = 13;                    // frame size registers
   localparam int POS_W  = 12;                    // column / row position
   localparam int SUM_W  = 12;                    // per-row strip count
   localparam int WIN_W  = SUM_W + 2;             // three-row window sum
   localparam int PROD_W = DIM_W + STRIP_IDX_W;   // width times strip number

   localparam int BAND_W     = 15;                // internal band arithmetic
   localparam int OUT_BAND_W = 14;                // packed band fields

   localparam int BAND_OFFSET = 10;
   localparam int BAND_LIMIT  = 15;
   localparam int BAND_MIN    = 5;

   localparam int CSR_INDEX_W = 2;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 32;
   localparam int RSP_PAD_W   = RSP_DATA_W - 2 * OUT_BAND_W - 1;
   localparam int KEEP_BIT    = 2 * OUT_BAND_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   // qualifying rows of every strip, handed over at frame end
   typedef struct packed {
      logic [STRIP_COUNT-1:0]            hit;
      logic [STRIP_COUNT-1:0][POS_W-1:0] first_row;
      logic [STRIP_COUNT-1:0][POS_W-1:0] last_row;
   } band_hits_type;

   // clip to the supported size, zero acts as one
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw,
                                                input logic [DIM_W-1:0] limit);
      if (raw > limit) begin
         return limit;
      end else if (raw == '0) begin
         return DIM_W'(1);
      end else begin
         return raw;
      end
   endfunction

   function automatic logic [OUT_BAND_W-1:0] sat_band(input logic signed [BAND_W-1:0] v);
      if (v > $signed(BAND_W'(8191))) begin
         return OUT_BAND_W'(8191);
      end else if (v < -$signed(BAND_W'(8192))) begin
         return OUT_BAND_W'(8192);
      end else begin
         return v[OUT_BAND_W-1:0];
      end
   endfunction

endpackage

FILE: sv/strip_row_band_finder_unit.sv
// ----------------------------------------------------------------------------
// strip_row_band_finder_unit
// Counts edge pixels per vertical strip and row, finds rows whose three-row
// window passes half the strip width, and reports one band per strip.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle, except that a frame end waits while the
// previous frame's bands are still going out. The last pixel of a frame passes
// the input register and loads the band emitter, whose eight bands follow one
// per cycle through the output register while the output is taken. A waiting
// frame end goes on once the last band is in the output register; stalls delay it.
// Reset: synchronous, active high; width 640, height 480, frame state cleared.
module strip_row_band_finder_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [srbf_pkg::REQ_DATA_W-1:0]     req_tdata,   // [0] pixel_on
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [13:0] band_start, [27:14] band_end, [28] keep_band
   output logic [srbf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [srbf_pkg::STRIP_IDX_W-1:0]    rsp_tuser,   // [2:0] strip_index
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [srbf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [srbf_pkg::DIM_W-1:0]          csr_data
);
   import srbf_pkg::*;

   logic [DIM_W-1:0] frame_width_ff, frame_height_ff;

   logic             in_valid_ff;
   logic             in_pixel_ff;

   logic [POS_W-1:0]                  col_ff, row_ff;
   logic [STRIP_COUNT-1:0][SUM_W-1:0] cur_sum_ff, old1_ff, old2_ff;
   logic [STRIP_COUNT-1:0]            hit_ff;
   logic [STRIP_COUNT-1:0][POS_W-1:0] first_ff, last_ff;

   logic [STRIP_COUNT-1:0][SUM_W-1:0] cur_sum_in;
   logic [STRIP_COUNT-1:0]            hit_in;
   logic [STRIP_COUNT-1:0][POS_W-1:0] first_in, last_in;

   logic [DIM_W-1:0]       w_eff, h_eff;
   logic [DIM_W-1:0]       bnd [STRIP_COUNT+1];
   logic [DIM_W-1:0]       thr;
   logic [WIN_W-1:0]       win_sum;
   logic                   in_strip, qual;
   logic                   row_end, frame_end, window_ok;
   logic [POS_W-1:0]       centre;
   logic                   in_advance, cfg_hit, frame_clear, emit_busy;
   band_hits_type          hits_snap;

   assign csr_ready = 1'b1;
   assign cfg_hit   = csr_valid &&
                      (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT);

   always_comb begin
      w_eff = eff_dim(frame_width_ff, DIM_W'(MAX_WIDTH));
      h_eff = eff_dim(frame_height_ff, DIM_W'(MAX_HEIGHT));
      // strip k starts at floor(w * k / strip count)
      for (int k = 0; k <= STRIP_COUNT; k++) begin
         bnd[k] = DIM_W'((PROD_W'(w_eff) * PROD_W'(k)) >> STRIP_IDX_W);
      end
      row_end   = ({1'b0, col_ff} + DIM_W'(1)) >= w_eff;
      frame_end = row_end && (({1'b0, row_ff} + DIM_W'(1)) >= h_eff);
      window_ok = row_ff >= POS_W'(2);
      centre    = row_ff - POS_W'(1);

      in_advance = in_valid_ff && (!frame_end || !emit_busy);
      req_tready = !in_valid_ff || in_advance;

      for (int k = 0; k < STRIP_COUNT; k++) begin
         in_strip = in_pixel_ff && ({1'b0, col_ff} >= bnd[k]) && ({1'b0, col_ff} < bnd[k+1]);
         cur_sum_in[k] = cur_sum_ff[k] + SUM_W'(in_strip);
         thr     = (bnd[k+1] - bnd[k]) >> 1;
         win_sum = WIN_W'(old2_ff[k]) + WIN_W'(old1_ff[k]) + WIN_W'(cur_sum_in[k]);
         qual    = row_end && window_ok && (win_sum > WIN_W'(thr));
         hit_in[k]   = hit_ff[k] || qual;
         first_in[k] = (qual && !hit_ff[k]) ? centre : first_ff[k];
         last_in[k]  = qual ? centre : last_ff[k];
      end

      hits_snap.hit       = hit_in;
      hits_snap.first_row = first_in;
      hits_snap.last_row  = last_in;

      frame_clear = cfg_hit || (in_advance && frame_end);
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= DIM_W'(640);
         frame_height_ff <= DIM_W'(480);
      end else if (csr_valid) begin
         if (csr_index == CSR_FRAME_WIDTH) begin
            frame_width_ff <= csr_data;
         end
         if (csr_index == CSR_FRAME_HEIGHT) begin
            frame_height_ff <= csr_data;
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (in_advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_pixel_ff <= req_tdata[0];
      end
   end

   // per-frame counting state
   always_ff @(posedge clock) begin
      if (reset || frame_clear) begin
         col_ff     <= '0;
         row_ff     <= '0;
         cur_sum_ff <= '0;
         old1_ff    <= '0;
         old2_ff    <= '0;
         hit_ff     <= '0;
         first_ff   <= '0;
         last_ff    <= '0;
      end else if (in_advance) begin
         if (row_end) begin
            col_ff     <= '0;
            row_ff     <= row_ff + POS_W'(1);
            old2_ff    <= old1_ff;
            old1_ff    <= cur_sum_in;
            cur_sum_ff <= '0;
            hit_ff     <= hit_in;
            first_ff   <= first_in;
            last_ff    <= last_in;
         end else begin
            col_ff     <= col_ff + POS_W'(1);
            cur_sum_ff <= cur_sum_in;
         end
      end
   end

   srbf_band_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (in_advance && frame_end),
      .hits       (hits_snap),
      .busy       (emit_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: sv/srbf_band_emit.sv
// ----------------------------------------------------------------------------
// srbf_band_emit
// Walks a finished frame's strips one per cycle while the output is taken,
// carries start and end from strip to strip, holds each in the output register.
// ----------------------------------------------------------------------------
module srbf_band_emit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  srbf_pkg::band_hits_type             hits,
   output logic                                busy,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [srbf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [srbf_pkg::STRIP_IDX_W-1:0]    rsp_tuser,
   output logic                                rsp_tlast
);
   import srbf_pkg::*;

   localparam logic signed [BAND_W-1:0] OFFSET = BAND_W'(BAND_OFFSET);
   localparam logic signed [BAND_W-1:0] LIMIT  = BAND_W'(BAND_LIMIT);
   localparam logic signed [BAND_W-1:0] MINLEN = BAND_W'(BAND_MIN);
   localparam logic [STRIP_IDX_W-1:0]   LAST_IDX = STRIP_IDX_W'(STRIP_COUNT - 1);

   band_hits_type            hits_ff;
   logic [STRIP_IDX_W-1:0]   idx_ff;
   logic                     busy_ff;
   logic signed [BAND_W-1:0] carry_s_ff, carry_e_ff;
   logic                     out_valid_ff;
   logic [OUT_BAND_W-1:0]    out_start_ff, out_end_ff;
   logic                     out_keep_ff, out_last_ff;
   logic [STRIP_IDX_W-1:0]   out_idx_ff;

   logic                     step;
   logic signed [BAND_W-1:0] s_sel, e_sel, s_in, e_raw, diff, e_in;
   logic                     over, keep_in;

   always_comb begin
      step = busy_ff && (!out_valid_ff || rsp_tready);
      if (hits_ff.hit[idx_ff]) begin
         s_sel = $signed({{(BAND_W-POS_W){1'b0}}, hits_ff.first_row[idx_ff]});
         e_sel = $signed({{(BAND_W-POS_W){1'b0}}, hits_ff.last_row[idx_ff]});
      end else begin
         s_sel = carry_s_ff;
         e_sel = carry_e_ff;
      end
      s_in  = s_sel + OFFSET;
      e_raw = e_sel - OFFSET;
      diff  = e_raw - s_in;
      over  = diff > LIMIT;
      e_in  = over ? s_in + LIMIT : e_raw;
      // a clipped band always spans the limit, which is above the minimum
      keep_in = over || (diff > MINLEN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (step) begin
            idx_ff <= idx_ff + STRIP_IDX_W'(1);
            if (idx_ff == LAST_IDX) begin
               busy_ff <= 1'b0;
            end
         end
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hits_ff    <= hits;
         carry_s_ff <= '0;
         carry_e_ff <= '0;
      end else if (step) begin
         carry_s_ff <= s_in;
         carry_e_ff <= e_in;
      end
      if (step) begin
         out_start_ff <= sat_band(s_in);
         out_end_ff   <= sat_band(e_in);
         out_keep_ff  <= keep_in;
         out_last_ff  <= (idx_ff == LAST_IDX);
         out_idx_ff   <= idx_ff;
      end
   end

   assign busy       = busy_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_keep_ff, out_end_ff, out_start_ff};
   assign rsp_tuser  = out_idx_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

FILE: sv/srbf_checker.sv
// ----------------------------------------------------------------------------
// srbf_checker
// Port-level checks on the band result stream, bound to the top level.
// ----------------------------------------------------------------------------
module srbf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [srbf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic [srbf_pkg::STRIP_IDX_W-1:0]    rsp_tuser,
   input logic                                rsp_tlast
);
   import srbf_pkg::*;

   logic signed [OUT_BAND_W:0] span;

   assign span = $signed({rsp_tdata[2*OUT_BAND_W-1], rsp_tdata[2*OUT_BAND_W-1:OUT_BAND_W]})
               - $signed({rsp_tdata[OUT_BAND_W-1], rsp_tdata[OUT_BAND_W-1:0]});

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled band item changed");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == STRIP_IDX_W'(STRIP_COUNT - 1))))
      else $error("tlast does not mark the last strip");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=>
         !rsp_tvalid || (rsp_tuser == STRIP_IDX_W'($past(rsp_tuser) + 1'b1)))
      else $error("strips out of order");

   a_span: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> span <= $signed((OUT_BAND_W+1)'(BAND_LIMIT)))
      else $error("band longer than the limit");

   a_keep: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[KEEP_BIT] == (span > $signed((OUT_BAND_W+1)'(BAND_MIN)))))
      else $error("keep flag disagrees with band length");

endmodule

bind strip_row_band_finder_unit srbf_checker u_srbf_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams binary edge frames of many sizes into the strip row band finder.
// A scoreboard recomputes the per-strip bands of each frame and compares
// every band item field by field while both stream sides idle and stall.
// ----------------------------------------------------------------------------
module tb;
   import srbf_pkg::*;

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int DRAIN_WAIT   = 16;
   localparam int LONG_HOLD    = 400;

   // indexes past the register list, writes there must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_ALTERNATE} rx_mode_type;
   typedef enum int {FILL_EMPTY, FILL_FULL, FILL_BAND} fill_type;

   typedef struct packed {
      logic [STRIP_IDX_W-1:0] strip;
      logic [OUT_BAND_W-1:0]  start_row;
      logic [OUT_BAND_W-1:0]  end_row;
      logic                   keep;
      logic                   last;
   } band_type;

   class band_scoreboard;
      logic [DIM_W-1:0] width_reg;
      logic [DIM_W-1:0] height_reg;
      int col;
      int row;
      int cur_sum[STRIP_COUNT];
      int prev_sum[STRIP_COUNT];
      int older_sum[STRIP_COUNT];
      int first_row[STRIP_COUNT];
      int last_row[STRIP_COUNT];
      bit found[STRIP_COUNT];
      band_type bands_q[$];
      int errors;
      int checked;
      int shown;

      function new();
         width_reg  = 640;
         height_reg = 480;
         errors     = 0;
         checked    = 0;
         shown      = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         col = 0;
         row = 0;
         for (int k = 0; k < STRIP_COUNT; k++) begin
            cur_sum[k]   = 0;
            prev_sum[k]  = 0;
            older_sum[k] = 0;
            first_row[k] = 0;
            last_row[k]  = 0;
            found[k]     = 1'b0;
         end
      endfunction

      function int eff_width();
         int w;
         w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
         return (w == 0) ? 1 : w;
      endfunction

      function int eff_height();
         int h;
         h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
         return (h == 0) ? 1 : h;
      endfunction

      function int strip_edge(int k);
         return eff_width() * k / STRIP_COUNT;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [DIM_W-1:0] value);
         case (idx)
            CSR_FRAME_WIDTH: begin
               width_reg = value;
               clear_frame();
            end
            CSR_FRAME_HEIGHT: begin
               height_reg = value;
               clear_frame();
            end
            default: ;
         endcase
      endfunction

      function logic [OUT_BAND_W-1:0] clip_band(int v);
         if (v > 8191) return OUT_BAND_W'(8191);
         if (v < -8192) return OUT_BAND_W'(-8192);
         return v[OUT_BAND_W-1:0];
      endfunction

      // three-row window check, then shift the row counts down
      function void close_row();
         int sum;
         int thr;
         if (row >= 2) begin
            for (int k = 0; k < STRIP_COUNT; k++) begin
               sum = older_sum[k] + prev_sum[k] + cur_sum[k];
               thr = (strip_edge(k + 1) - strip_edge(k)) / 2;
               if (sum > thr) begin
                  if (!found[k]) first_row[k] = row - 1;
                  last_row[k] = row - 1;
                  found[k]    = 1'b1;
               end
            end
         end
         for (int k = 0; k < STRIP_COUNT; k++) begin
            older_sum[k] = prev_sum[k];
            prev_sum[k]  = cur_sum[k];
            cur_sum[k]   = 0;
         end
      endfunction

      // strips without a hit inherit the previous strip's adjusted band
      function void queue_bands();
         int s;
         int e;
         int carry_s;
         int carry_e;
         band_type b;
         carry_s = 0;
         carry_e = 0;
         for (int k = 0; k < STRIP_COUNT; k++) begin
            s = found[k] ? first_row[k] : carry_s;
            e = found[k] ? last_row[k] : carry_e;
            s = s + BAND_OFFSET;
            e = e - BAND_OFFSET;
            if (e - s > BAND_LIMIT) e = s + BAND_LIMIT;
            b.strip     = STRIP_IDX_W'(k);
            b.start_row = clip_band(s);
            b.end_row   = clip_band(e);
            b.keep      = (e - s > BAND_MIN);
            b.last      = (k == STRIP_COUNT - 1);
            bands_q.insert(bands_q.size(), b);
            carry_s = s;
            carry_e = e;
         end
      endfunction

      function void note_pixel(bit on);
         if (on) begin
            for (int k = 0; k < STRIP_COUNT; k++) begin
               if (col >= strip_edge(k) && col < strip_edge(k + 1)) begin
                  cur_sum[k] = (cur_sum[k] + 1) & 12'hFFF;
                  break;
               end
            end
         end
         if (col + 1 >= eff_width()) begin
            col = 0;
            close_row();
            if (row + 1 >= eff_height()) begin
               queue_bands();
               clear_frame();
            end else begin
               row++;
            end
         end else begin
            col++;
         end
      endfunction

      function void report(string what, int exp_val, int act_val);
         errors++;
         if (shown < 40) begin
            shown++;
            $display("%0t tb: %s mismatch, expected %0d actual %0d",
                     $time, what, exp_val, act_val);
         end
      endfunction

      function void check_band(band_type got);
         band_type exp_band;
         checked++;
         if (bands_q.size() == 0) begin
            errors++;
            if (shown < 40) begin
               shown++;
               $display("%0t tb: unexpected band item, expected none actual strip %0d",
                        $time, got.strip);
            end
            return;
         end
         exp_band = bands_q.pop_front();
         if (got.strip != exp_band.strip)
            report("strip_index", exp_band.strip, got.strip);
         if (got.start_row != exp_band.start_row)
            report("band_start", $signed(exp_band.start_row), $signed(got.start_row));
         if (got.end_row != exp_band.end_row)
            report("band_end", $signed(exp_band.end_row), $signed(got.end_row));
         if (got.keep != exp_band.keep)
            report("keep_band", exp_band.keep, got.keep);
         if (got.last != exp_band.last)
            report("last_strip", exp_band.last, got.last);
      endfunction

      function int pending();
         return bands_q.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [STRIP_IDX_W-1:0] rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [DIM_W-1:0]       csr_data   = '0;

   band_scoreboard sb = new();

   int cycle_count = 0;
   int pixels_sent = 0;
   int csr_writes  = 0;
   int burst_left  = 0;
   bit steady      = 1'b0;
   bit hold_request = 1'b0;
   int hold_left   = 0;
   int long_holds  = 0;
   int full_pauses = 0;
   int rx_tick     = 0;
   rx_mode_type rx_mode = RX_OPEN;
   band_type seen_band;

   strip_row_band_finder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // output side: stall pattern redrawn at random from four modes, long hold on request
   always @(posedge clock) begin
      rx_tick++;
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = LONG_HOLD;
         long_holds++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (rx_tick % 64 == 0) rx_mode = rx_mode_type'($urandom_range(0, 3));
         case (rx_mode)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:   rsp_tready <= rx_tick[0];
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_band.strip     = rsp_tuser;
         seen_band.start_row = rsp_tdata[OUT_BAND_W-1:0];
         seen_band.end_row   = rsp_tdata[2*OUT_BAND_W-1:OUT_BAND_W];
         seen_band.keep      = rsp_tdata[KEEP_BIT];
         seen_band.last      = rsp_tlast;
         sb.check_band(seen_band);
      end
   end

   task automatic send_pixel(input bit on);
      int gap;
      if (burst_left == 0) begin
         gap = steady ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-1){1'b0}}, on};
      do @(posedge clock); while (!req_tready);
      sb.note_pixel(on);
      pixels_sent++;
      burst_left--;
   endtask

   // stop offering, let every pending band come out, then settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [DIM_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_reg(idx, value);
      csr_writes++;
      @(posedge clock);
   endtask

   // dense rows in a random span, sparse elsewhere, so bands form; or all empty/full
   task automatic send_frame(input int n_pixels);
      int w;
      int h;
      int lo;
      int hi;
      int pct;
      int pick;
      fill_type fill;
      w    = sb.eff_width();
      h    = sb.eff_height();
      lo   = $urandom_range(0, h - 1);
      hi   = $urandom_range(lo, h - 1);
      pick = $urandom_range(0, 5);
      fill = (pick == 0) ? FILL_EMPTY : (pick == 1) ? FILL_FULL : FILL_BAND;
      pct  = 0;
      for (int i = 0; i < n_pixels; i++) begin
         if (i % w == 0) begin
            case (fill)
               FILL_EMPTY: pct = 0;
               FILL_FULL:  pct = 100;
               default: begin
                  if (i / w >= lo && i / w <= hi) pct = $urandom_range(60, 100);
                  else pct = $urandom_range(0, 30);
               end
            endcase
         end
         send_pixel($urandom_range(0, 99) < pct);
      end
   endtask

   task automatic run_phase(input logic [DIM_W-1:0] w_raw, input logic [DIM_W-1:0] h_raw,
                            input int frames, input bit with_tail);
      int frame_px;
      drain();
      write_csr(CSR_FRAME_WIDTH, w_raw);
      write_csr(CSR_FRAME_HEIGHT, h_raw);
      if ($urandom_range(0, 3) == 0) write_csr(CSR_SPARE_3, DIM_W'($urandom));
      steady   = ($urandom_range(0, 3) == 0);
      frame_px = sb.eff_width() * sb.eff_height();
      for (int f = 0; f < frames; f++) begin
         send_frame(frame_px);
         if ($urandom_range(0, 3) == 0) begin
            drain();
            full_pauses++;
         end
      end
      // a partial frame left behind is dropped by the next register write
      if (with_tail && frame_px > 1) send_frame($urandom_range(1, frame_px - 1));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // partial frame at the reset size, abandoned by the first write
      send_pixel(1'b1);
      send_pixel(1'b0);
      send_pixel(1'b1);
      send_pixel(1'b1);
      send_pixel(1'b0);
      drain();
      // zero sizes act as one: every pixel closes a frame
      write_csr(CSR_FRAME_WIDTH, '0);
      write_csr(CSR_FRAME_HEIGHT, '0);
      send_pixel(1'b1);
      send_pixel(1'b0);
      drain();
      write_csr(CSR_SPARE_2, '1);
      write_csr(CSR_SPARE_3, DIM_W'(8));
      send_pixel(1'b1);
      drain();
      // smallest legal frame, fully set
      write_csr(CSR_FRAME_WIDTH, DIM_W'(8));
      write_csr(CSR_FRAME_HEIGHT, DIM_W'(3));
      for (int i = 0; i < 24; i++) send_pixel(1'b1);

      run_phase(8, 3, 1, 1'b1);
      run_phase(11, 4, 1, 1'b0);

      // output held off while single-pixel frames keep coming
      drain();
      write_csr(CSR_FRAME_WIDTH, '0);
      write_csr(CSR_FRAME_HEIGHT, '0);
      steady       = 1'b1;
      hold_request = 1'b1;
      for (int i = 0; i < 30; i++) send_frame(1);

      // one column: only the last strip owns pixels, tall enough for kept bands
      run_phase(0, 40, 2, 1'b0);
      run_phase(9, 0, 2, 1'b1);
      run_phase(8, 2, 1, 1'b1);

      // oversized sizes clip to the largest frame, a few pixels then abandoned
      drain();
      write_csr(CSR_FRAME_WIDTH, '1);
      write_csr(CSR_FRAME_HEIGHT, '1);
      for (int i = 0; i < 6; i++) send_pixel(1'b1);

      run_phase(DIM_W'($urandom_range(8, 12)), DIM_W'(3), 1, 1'b0);

      drain();
      $display("tb: %0d pixels streamed, %0d band items checked, %0d register writes",
               pixels_sent, sb.checked, csr_writes);
      $display("tb: %0d long output holds, %0d input pauses until drained",
               long_holds, full_pauses);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/srbf_pkg.sv
sv/srbf_band_emit.sv
sv/strip_row_band_finder_unit.sv
sv/srbf_checker.sv
tb/tb.sv
